@@ hw/rtl/aoc_pkg.sv @@
// Shared types, constants and helper functions for the alpha-over compositor.
`timescale 1ns / 1ps
`default_nettype none

package aoc_pkg;

  localparam int unsigned CHAN_W   = 8;   // colour / alpha channel width
  localparam int unsigned LANES    = 3;   // red, green, blue
  localparam int unsigned WGT_W    = 16;  // weights and denominator, max 65025
  localparam int unsigned NUM_W    = 24;  // colour numerator, max 255*65025
  localparam int unsigned DSH_W    = NUM_W - 1; // divisor aligned to quotient msb
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned DIV_STAGES   = CHAN_W;
  localparam int unsigned LATENCY      = FRONT_STAGES + DIV_STAGES;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // Lane order within the packed arrays
  localparam int unsigned LANE_RED   = 0;
  localparam int unsigned LANE_GREEN = 1;
  localparam int unsigned LANE_BLUE  = 2;

  typedef logic [LANES-1:0][CHAN_W-1:0] chan_vec_t;
  typedef logic [LANES-1:0][NUM_W-1:0]  num_vec_t;

  // Weights and numerators leaving the multiply stages
  typedef struct packed {
    logic                 valid;
    logic [WGT_W-1:0]     denom;
    num_vec_t             num;
  } front_bus_t;

  // State carried down the divider pipeline
  typedef struct packed {
    logic                 valid;
    logic                 zero;   // both alphas zero
    logic [DSH_W-1:0]     dsh;    // divisor shifted to the current quotient bit
    num_vec_t             rem;
    chan_vec_t            quo;
    logic [CHAN_W-1:0]    alpha;
  } div_bus_t;

  // Truncating divide by 255 for values up to 65025: estimate never overshoots
  // and is at most one short, so one compare fixes it.
  function automatic logic [CHAN_W-1:0] div255(input logic [WGT_W-1:0] d);
    logic [WGT_W-1:0]   t;
    logic [CHAN_W-1:0]  q;
    logic [WGT_W:0]     r;
    t = d + {8'd0, d[WGT_W-1:8]};
    q = t[WGT_W-1:8];
    r = {1'b0, d} - {1'b0, q, 8'd0} + {9'd0, q};
    if (r >= 17'd255) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/alpha_over_compositor_unit.sv @@
// Top level of the Porter-Duff over compositor for straight-alpha RGBA8 pixels.
`timescale 1ns / 1ps
`default_nettype none

// Composites one top pixel over one base pixel per clock. A transfer is taken
// at every edge where start is high; busy is always low because the pipeline
// never stalls. Each result appears on the out_ ports once it has passed the
// pipeline, marked by a one-cycle out_valid, and must be captured then:
// the receiver cannot hold it off. The pipeline is two multiply stages
// (weights, then denominator and numerators) followed by eight restoring
// division stages, one quotient bit each, run for the three colour channels
// side by side. Output alpha is the denominator divided by 255, worked out
// beside the first division step and carried along. Colours are truncated
// quotients; when both alphas are zero the pixel comes out all zeros.

module alpha_over_compositor_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_top_red,
  input  wire logic [7:0] in_top_green,
  input  wire logic [7:0] in_top_blue,
  input  wire logic [7:0] in_top_alpha,
  input  wire logic [7:0] in_base_red,
  input  wire logic [7:0] in_base_green,
  input  wire logic [7:0] in_base_blue,
  input  wire logic [7:0] in_base_alpha,
  output logic            out_valid,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha
);

  aoc_pkg::chan_vec_t  top_col, base_col;
  aoc_pkg::front_bus_t front_bus;
  aoc_pkg::div_bus_t   div_bus [aoc_pkg::DIV_STAGES+1];
  aoc_pkg::div_bus_t   last;

  // No back-pressure anywhere, so a new pixel pair is taken every cycle
  assign busy = 1'b0;

  assign top_col[aoc_pkg::LANE_RED]    = in_top_red;
  assign top_col[aoc_pkg::LANE_GREEN]  = in_top_green;
  assign top_col[aoc_pkg::LANE_BLUE]   = in_top_blue;
  assign base_col[aoc_pkg::LANE_RED]   = in_base_red;
  assign base_col[aoc_pkg::LANE_GREEN] = in_base_green;
  assign base_col[aoc_pkg::LANE_BLUE]  = in_base_blue;

  // Stages 1 and 2: D = Ao*255 + Au*(255-Ao), numerators Co*Ao*255 + Cu*Au*(255-Ao)
  aoc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !busy),
    .top_col    (top_col),
    .top_alpha  (in_top_alpha),
    .base_col   (base_col),
    .base_alpha (in_base_alpha),
    .front_out  (front_bus)
  );

  // Load the divider: divisor aligned to quotient bit 7, since every
  // numerator is below 256*D the quotient fits in eight bits.
  always_comb begin
    div_bus[0].valid = front_bus.valid;
    div_bus[0].zero  = (front_bus.denom == '0);
    div_bus[0].dsh   = {front_bus.denom, 7'd0};
    div_bus[0].rem   = front_bus.num;
    div_bus[0].quo   = '0;
    div_bus[0].alpha = aoc_pkg::div255(front_bus.denom);
  end

  // Stages 3 to 10: one quotient bit per stage, msb first
  for (genvar s = 0; s < aoc_pkg::DIV_STAGES; s++) begin : g_div
    aoc_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_in  (div_bus[s]),
      .step_out (div_bus[s+1])
    );
  end

  assign last = div_bus[aoc_pkg::DIV_STAGES];

  // With D zero every compare passes, so the quotient is forced to zero here
  assign out_valid = last.valid;
  assign out_red   = last.zero ? 8'd0 : last.quo[aoc_pkg::LANE_RED];
  assign out_green = last.zero ? 8'd0 : last.quo[aoc_pkg::LANE_GREEN];
  assign out_blue  = last.zero ? 8'd0 : last.quo[aoc_pkg::LANE_BLUE];
  assign out_alpha = last.alpha;

  // Every transfer comes out after the fixed latency, and nothing else does
  a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(aoc_pkg::LATENCY) out_valid)
    else $error("transfer did not produce a result");

  a_latency_bwd : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, aoc_pkg::LATENCY))
    else $error("result without a matching transfer");

  // Both alphas zero: the whole pixel is zero
  a_zero_pair : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && in_top_alpha == 8'd0 && in_base_alpha == 8'd0,
                       aoc_pkg::LATENCY)
    |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 &&
         out_alpha == 8'd0))
    else $error("transparent pair not cleared");

  // Opaque top pixel passes straight through
  a_opaque_top : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && in_top_alpha == 8'd255, aoc_pkg::LATENCY)
    |-> (out_alpha == 8'd255 &&
         out_red == $past(in_top_red, aoc_pkg::LATENCY) &&
         out_green == $past(in_top_green, aoc_pkg::LATENCY) &&
         out_blue == $past(in_top_blue, aoc_pkg::LATENCY)))
    else $error("opaque top pixel altered");

endmodule

`default_nettype wire

@@ hw/rtl/aoc_front.sv @@
// Weight and numerator stages: two register stages of products.
`timescale 1ns / 1ps
`default_nettype none

module aoc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire aoc_pkg::chan_vec_t  top_col,
  input  wire logic [7:0]          top_alpha,
  input  wire aoc_pkg::chan_vec_t  base_col,
  input  wire logic [7:0]          base_alpha,
  output aoc_pkg::front_bus_t      front_out
);

  // stage 1: weights
  logic                 v1_r;
  logic [15:0]          wo_r, wo_nxt;
  logic [15:0]          wu_r, wu_nxt;
  aoc_pkg::chan_vec_t   co_r, cu_r;

  // stage 2: denominator and numerators
  logic                 v2_r;
  logic [15:0]          d_r, d_nxt;
  aoc_pkg::num_vec_t    num_r, num_nxt;

  logic [16:0]          d_sum;
  logic [23:0]          p_top, p_base;
  logic [24:0]          n_sum [aoc_pkg::LANES];

  always_comb begin
    wo_nxt = {top_alpha, 8'd0} - {8'd0, top_alpha};
    wu_nxt = {8'd0, base_alpha} * {8'd0, aoc_pkg::CHAN_MAX - top_alpha};
  end

  always_comb begin
    p_top  = '0;
    p_base = '0;
    d_sum = {1'b0, wo_r} + {1'b0, wu_r};
    d_nxt = d_sum[15:0];  // at most 65025
    for (int i = 0; i < aoc_pkg::LANES; i++) begin
      p_top      = {16'd0, co_r[i]} * {8'd0, wo_r};
      p_base     = {16'd0, cu_r[i]} * {8'd0, wu_r};
      n_sum[i]   = {1'b0, p_top} + {1'b0, p_base};
      num_nxt[i] = n_sum[i][23:0];  // at most 255*65025
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    wo_r  <= wo_nxt;
    wu_r  <= wu_nxt;
    co_r  <= top_col;
    cu_r  <= base_col;
    d_r   <= d_nxt;
    num_r <= num_nxt;
  end

  assign front_out.valid = v2_r;
  assign front_out.denom = d_r;
  assign front_out.num   = num_r;

endmodule

`default_nettype wire

@@ hw/rtl/aoc_div_step.sv @@
// One restoring division step for all three colour lanes.
`timescale 1ns / 1ps
`default_nettype none

module aoc_div_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aoc_pkg::div_bus_t step_in,
  output aoc_pkg::div_bus_t      step_out
);

  aoc_pkg::div_bus_t bus_r, bus_nxt;
  logic [aoc_pkg::NUM_W-1:0] dsh_ext;
  logic ge;

  always_comb begin
    bus_nxt = step_in;
    dsh_ext = {1'b0, step_in.dsh};
    for (int i = 0; i < aoc_pkg::LANES; i++) begin
      ge = step_in.rem[i] >= dsh_ext;
      bus_nxt.rem[i] = ge ? (step_in.rem[i] - dsh_ext) : step_in.rem[i];
      bus_nxt.quo[i] = {step_in.quo[i][aoc_pkg::CHAN_W-2:0], ge};
    end
    bus_nxt.dsh = step_in.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r <= '0;
    end else begin
      bus_r <= bus_nxt;
    end
  end

  assign step_out = bus_r;

endmodule

`default_nettype wire
